FILE: sv/sfr_pkg.sv
// Package for the streaming find-and-replace unit.
// Holds widths, defaults, register and operation codes, and the cell control structs.
// No dependencies.
package sfr_pkg;

  localparam int DATA_W      = 8;
  localparam int CFG_W       = 64;
  localparam int LEN_W       = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;

  localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN  = 2'd0,
    CFG_PAT_LEN  = 2'd1,
    CFG_REPL     = 2'd2,
    CFG_REPL_LEN = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // Control for one window cell.
  typedef struct packed {
    logic load;
    logic sel_new;
  } win_ctl_t;

  // Control for one output cell.
  typedef struct packed {
    logic load;
    logic shift;
  } out_ctl_t;

endpackage

FILE: sv/sfr_win_cell.sv
// One cell of the pending window: holds a byte and compares it with every pattern byte.
// Depends on sfr_pkg.
module sfr_win_cell #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX
) (
  input  logic                              clk,
  input  sfr_pkg::win_ctl_t                 ctl,
  input  logic [sfr_pkg::DATA_W-1:0]        d,
  input  logic [sfr_pkg::DATA_W-1:0]        in_byte,
  input  logic [sfr_pkg::CFG_W-1:0]         pattern,
  output logic [sfr_pkg::DATA_W-1:0]        cur,
  output logic [PATTERN_MAX-1:0]            eq
);

  logic [sfr_pkg::DATA_W-1:0] held;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= d;
    end
  end

  // The cell just past the filled part shows the incoming byte.
  assign cur = ctl.sel_new ? in_byte : held;

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      eq[j] = (cur == pattern[sfr_pkg::DATA_W*j +: sfr_pkg::DATA_W]);
    end
  end

endmodule

FILE: sv/sfr_out_cell.sv
// One cell of the output chain: loads a result byte or takes its right neighbour's byte.
// Depends on sfr_pkg.
module sfr_out_cell (
  input  logic                          clk,
  input  sfr_pkg::out_ctl_t             ctl,
  input  logic [sfr_pkg::DATA_W-1:0]    load_byte,
  input  logic [sfr_pkg::DATA_W-1:0]    right_byte,
  output logic [sfr_pkg::DATA_W-1:0]    q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_byte;
    end else if (ctl.shift) begin
      q <= right_byte;
    end
  end

endmodule

FILE: sv/stream_find_replace_unit.sv
// Top level of the streaming find-and-replace unit.
// Depends on sfr_pkg, sfr_win_cell and sfr_out_cell.
//
//  channel   direction  beat contents
//  s_*       in         tdata[7:0] in_byte, tuser[0] operation, one input item per beat
//  m_*       out        tdata[7:0] out_byte, tlast run_last, one output byte per beat
//  cfg_*     in         register write: cfg_addr index, cfg_data value, cfg_we strobe
//
// An accepted input item's first output byte shows the next cycle when the output chain is
// free, and an item that yields n bytes holds the chain until all n bytes are sent.
// Items that yield one byte or none flow at one per cycle with m_tready high.
// A one-item skid register in front of the output chain keeps s_tready registered; it drops
// only while that register is occupied. Synchronous reset empties the window, the output
// chain and the skid register and restores the register defaults; no clearing pass is needed.
module stream_find_replace_unit #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sfr_pkg::DATA_W-1:0]        s_tdata,   // [7:0] in_byte
  input  logic                              s_tuser,   // [0] operation
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfr_pkg::DATA_W-1:0]        m_tdata,   // [7:0] out_byte
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sfr_pkg::CFG_W-1:0]         cfg_data
);

  localparam int QD = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam int RW = $clog2(REPLACE_MAX + 1);
  localparam int CW = $clog2(QD + 1);
  localparam int DW = sfr_pkg::DATA_W;

  // Configuration registers.
  logic [sfr_pkg::CFG_W-1:0] pattern;
  logic [sfr_pkg::LEN_W-1:0] pat_len;
  logic [sfr_pkg::CFG_W-1:0] repl;
  logic [sfr_pkg::LEN_W-1:0] repl_len;

  // Window and line state.
  logic [FW-1:0] fill, fill_next;
  logic          line_open, line_open_next;

  // Output chain and skid register.
  logic [CW-1:0] ocnt;
  logic [CW-1:0] pcnt;
  logic [DW-1:0] pbuf [QD];
  logic [DW-1:0] oq   [QD];

  logic [FW-1:0] plen;
  logic [RW-1:0] rlen;
  logic [FW-1:0] efill;
  logic          acc, is_end, is_nl, flush, hit;
  logic [DW-1:0] e  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq [PATTERN_MAX];
  logic [DW-1:0] wd [PATTERN_MAX];
  logic [PATTERN_MAX:0] pre, cand;
  logic [FW-1:0] ksel;
  logic [DW-1:0] res [QD];
  logic [CW-1:0] n;
  logic          act_free, pvalid, pop, load_act;
  logic [DW-1:0] src [QD];
  logic [CW-1:0] src_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern  <= '0;
      pat_len  <= sfr_pkg::LEN_W'(1);
      repl     <= '0;
      repl_len <= sfr_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (sfr_pkg::cfg_reg_t'(cfg_addr))
        sfr_pkg::CFG_PATTERN:  pattern  <= cfg_data;
        sfr_pkg::CFG_PAT_LEN:  pat_len  <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REPL:     repl     <= cfg_data;
        sfr_pkg::CFG_REPL_LEN: repl_len <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one, and any length above the maximum acts as the maximum.
  always_comb begin
    if (pat_len == '0) begin
      plen = FW'(1);
    end else if (pat_len > sfr_pkg::LEN_W'(PATTERN_MAX)) begin
      plen = FW'(PATTERN_MAX);
    end else begin
      plen = FW'(pat_len);
    end
    if (repl_len == '0) begin
      rlen = RW'(1);
    end else if (repl_len > sfr_pkg::LEN_W'(REPLACE_MAX)) begin
      rlen = RW'(REPLACE_MAX);
    end else begin
      rlen = RW'(repl_len);
    end
  end

  assign pvalid = (pcnt != '0);
  assign s_tready = !pvalid;
  assign acc    = s_tvalid && s_tready;
  assign is_end = (sfr_pkg::op_t'(s_tuser) == sfr_pkg::OP_END);
  assign is_nl  = !is_end && (s_tdata == sfr_pkg::NEWLINE);
  assign flush  = is_end || is_nl;
  assign efill  = fill + FW'(1);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
    sfr_pkg::win_ctl_t wctl;
    assign wctl.load    = acc;
    assign wctl.sel_new = (fill == FW'(i));
    sfr_win_cell #(.PATTERN_MAX(PATTERN_MAX)) u_cell (
      .clk     (clk),
      .ctl     (wctl),
      .d       (wd[i]),
      .in_byte (s_tdata),
      .pattern (pattern),
      .cur     (e[i]),
      .eq      (eq[i])
    );
  end

  // pre[k]: the window from byte k onwards is a prefix of the pattern.
  // cand[k]: it is also shorter than the pattern, so it may stay pending.
  always_comb begin
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      pre[k] = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (k + j < PATTERN_MAX) begin
          if ((k + j) < int'(efill) && !eq[k+j][j]) begin
            pre[k] = 1'b0;
          end
        end
      end
      cand[k] = pre[k] && ((int'(efill) - k) < int'(plen));
    end
    ksel = FW'(PATTERN_MAX);
    for (int k = PATTERN_MAX; k >= 0; k--) begin
      if (cand[k]) begin
        ksel = FW'(k);
      end
    end
    hit = (efill == plen) && pre[0];
  end

  // Surviving bytes move left by the number of bytes sent out.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      wd[i] = '0;
      for (int s = 0; s < PATTERN_MAX; s++) begin
        if (ksel == FW'(s) && i + s < PATTERN_MAX) begin
          wd[i] = e[i+s];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      if (!flush && hit) begin
        res[i] = (i < REPLACE_MAX) ? repl[DW*i +: DW] : '0;
      end else if (flush && fill == FW'(i)) begin
        res[i] = sfr_pkg::NEWLINE;
      end else begin
        res[i] = (i < PATTERN_MAX) ? e[i] : '0;
      end
    end
    if (is_end) begin
      n              = CW'(fill) + CW'(line_open);
      fill_next      = '0;
      line_open_next = 1'b0;
    end else if (is_nl) begin
      n              = CW'(fill) + CW'(1);
      fill_next      = '0;
      line_open_next = 1'b0;
    end else if (hit) begin
      n              = CW'(rlen);
      fill_next      = '0;
      line_open_next = 1'b1;
    end else begin
      n              = CW'(ksel);
      fill_next      = efill - ksel;
      line_open_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      line_open <= 1'b0;
    end else if (acc) begin
      fill      <= fill_next;
      line_open <= line_open_next;
    end
  end

  assign pop      = m_tvalid && m_tready;
  assign act_free = (ocnt == '0) || (ocnt == CW'(1) && m_tready);
  assign load_act = act_free && (pvalid || (acc && n != '0));
  assign src_cnt  = pvalid ? pcnt : n;

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      src[i] = pvalid ? pbuf[i] : res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n != '0 && !act_free) begin
      for (int i = 0; i < QD; i++) begin
        pbuf[i] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= '0;
      ocnt <= '0;
    end else begin
      if (acc && n != '0 && !act_free) begin
        pcnt <= n;
      end else if (act_free && pvalid) begin
        pcnt <= '0;
      end
      if (load_act) begin
        ocnt <= src_cnt;
      end else if (pop) begin
        ocnt <= ocnt - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < QD; i++) begin : g_out
    sfr_pkg::out_ctl_t octl;
    logic [DW-1:0]     right;
    assign octl.load  = load_act;
    assign octl.shift = pop;
    if (i + 1 < QD) begin : g_mid
      assign right = oq[i+1];
    end else begin : g_end
      assign right = '0;
    end
    sfr_out_cell u_cell (
      .clk        (clk),
      .ctl        (octl),
      .load_byte  (src[i]),
      .right_byte (right),
      .q          (oq[i])
    );
  end

  assign m_tvalid = (ocnt != '0);
  assign m_tlast  = (ocnt == CW'(1));
  assign m_tdata  = oq[0];

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < FW'(PATTERN_MAX))
    else $error("window holds as many bytes as the pattern maximum");

  a_skid_behind_active: assert property (@(posedge clk) disable iff (rst)
    pvalid |-> (ocnt != '0))
    else $error("skid register occupied while the output chain is empty");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && flush) |=> (fill == '0))
    else $error("window not empty after a newline or end of stream");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (acc && n != '0) |=> m_tvalid)
    else $error("accepted item with results left the output idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ocnt <= CW'(QD)) && (pcnt <= CW'(QD)))
    else $error("output count beyond the chain depth");
`endif

endmodule

FILE: tb/sv/stream_find_replace_unit_tb.sv
// Self-checking testbench for stream_find_replace_unit: a queue-fed beat driver, an output
// monitor and an in-bench find-and-replace predictor, run over several register settings.
// Depends on sfr_pkg and the RTL of stream_find_replace_unit only.
`timescale 1ns / 100ps

module stream_find_replace_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    sfr_pkg::op_t op;
    logic [7:0]   ch;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [sfr_pkg::DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [sfr_pkg::DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sfr_pkg::CFG_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and of the window.
  logic [63:0] pat_word = '0;
  logic [3:0]  pat_len = 4'd1;
  logic [63:0] rep_word = '0;
  logic [3:0]  rep_len = 4'd1;
  logic [7:0]  win_buf [8];
  int unsigned win_fill = 0;
  bit          line_open = 1'b0;

  in_beat_t  item_q[$];
  out_beat_t expected_bytes[$];
  logic [7:0] step_bytes[$];

  bit idle_on = 1'b1;
  bit in_beat_done = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int items_taken = 0;
  int bytes_checked = 0;
  int replacements = 0;
  int settings_used = 1;
  logic [7:0] alpha [4];
  in_beat_t nxt;

  stream_find_replace_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned clamp_len(logic [3:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void emit(logic [7:0] ch);
    if (step_bytes.size() < 8) step_bytes.push_back(ch);
  endfunction

  function automatic bit window_is_prefix();
    for (int i = 0; i < win_fill; i++)
      if (win_buf[i] != pat_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void flush_window();
    for (int i = 0; i < win_fill; i++) emit(win_buf[i]);
    win_fill = 0;
  endfunction

  // Works out the bytes that one accepted beat releases and queues them as expectations.
  function automatic void rewrite_item(sfr_pkg::op_t op, logic [7:0] ch);
    int unsigned plen;
    int unsigned rlen;
    plen = clamp_len(pat_len, sfr_pkg::PATTERN_MAX);
    rlen = clamp_len(rep_len, sfr_pkg::REPLACE_MAX);
    step_bytes.delete();
    if (op == sfr_pkg::OP_END) begin
      flush_window();
      if (line_open) emit(sfr_pkg::NEWLINE);
      line_open = 1'b0;
    end else if (ch == sfr_pkg::NEWLINE) begin
      flush_window();
      emit(sfr_pkg::NEWLINE);
      line_open = 1'b0;
    end else begin
      line_open = 1'b1;
      if (win_fill < 8) begin
        win_buf[win_fill] = ch;
        win_fill++;
      end
      if (win_fill == plen && window_is_prefix()) begin
        for (int i = 0; i < rlen; i++) emit(rep_word[8*i +: 8]);
        win_fill = 0;
        replacements++;
      end else begin
        // Release leading bytes until what is left could still start a match.
        while (win_fill > 0 && (win_fill >= plen || !window_is_prefix())) begin
          emit(win_buf[0]);
          for (int i = 1; i < 8; i++) win_buf[i-1] = win_buf[i];
          win_fill--;
        end
      end
    end
    foreach (step_bytes[i])
      expected_bytes.push_back('{ch: step_bytes[i], last: (i == step_bytes.size() - 1)});
  endfunction

  // Acceptance of input beats and checking of output beats, both at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        rewrite_item(sfr_pkg::op_t'(s_tuser), s_tdata);
        in_beat_done = 1'b1;
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: output beat %02h (tlast %0b) arrived with nothing expected",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          if (m_tdata !== expected_bytes[0].ch) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, expected_bytes[0].ch, m_tdata);
            mismatches++;
          end
          if (m_tlast !== expected_bytes[0].last) begin
            $display("%0t: run_last mismatch, expected %0b, got %0b",
                     $time, expected_bytes[0].last, m_tlast);
            mismatches++;
          end
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  // Input driver: holds a beat until it is taken, with random gaps between beats.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_beat_done)) begin
      in_beat_done = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (item_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        in_gap = $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else begin
        nxt = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.ch;
        s_tuser  <= nxt.op;
      end
    end
  end

  // Output back-pressure in bursts.
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(sfr_pkg::cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      sfr_pkg::CFG_PATTERN:  pat_word = val;
      sfr_pkg::CFG_PAT_LEN:  pat_len = val[3:0];
      sfr_pkg::CFG_REPL:     rep_word = val;
      sfr_pkg::CFG_REPL_LEN: rep_len = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(sfr_pkg::op_t op, logic [7:0] ch);
    item_q.push_back('{op: op, ch: ch});
  endtask

  // Waits until every beat is taken and every expected byte has come, then lets the
  // window logic settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (item_q.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A length word, sometimes with junk above the four bits that count.
  function automatic logic [63:0] len_word(logic [3:0] len);
    logic [63:0] w;
    w = '0;
    if ($urandom_range(0, 1) == 1) w = {$urandom(), $urandom()};
    w[3:0] = len;
    return w;
  endfunction

  task automatic random_config(int phase);
    logic [63:0] pw;
    logic [63:0] rw;
    logic [3:0]  pl;
    logic [3:0]  rl;
    int unsigned eff;
    for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) alpha[3] = sfr_pkg::NEWLINE;
    case (phase)
      0: begin pl = 4'd8; rl = 4'd8; end
      1: begin pl = 4'd1; rl = 4'd1; end
      default: begin
        pl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
        rl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      end
    endcase
    pw = {$urandom(), $urandom()};
    eff = clamp_len(pl, sfr_pkg::PATTERN_MAX);
    for (int i = 0; i < eff; i++) pw[8*i +: 8] = alpha[$urandom_range(0, 3)];
    rw = {$urandom(), $urandom()};
    if ($urandom_range(0, 6) == 0) begin
      rw = pw;
      rl = pl;
    end
    write_reg(sfr_pkg::CFG_PATTERN, pw);
    write_reg(sfr_pkg::CFG_PAT_LEN, len_word(pl));
    write_reg(sfr_pkg::CFG_REPL, rw);
    write_reg(sfr_pkg::CFG_REPL_LEN, len_word(rl));
    settings_used++;
  endtask

  // Mostly lines of text seeded with whole and broken copies of the pattern, plus noise.
  task automatic fill_phase(int n_items);
    int pushed;
    int unsigned eff;
    int line_len;
    int r;
    int cut;
    pushed = 0;
    eff = clamp_len(pat_len, sfr_pkg::PATTERN_MAX);
    while (pushed < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        line_len = $urandom_range(0, 16);
        for (int j = 0; j < line_len; j++) begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            for (int i = 0; i < eff; i++) push_item(sfr_pkg::OP_DATA, pat_word[8*i +: 8]);
            pushed += eff;
          end else if (r == 3 && eff > 1) begin
            cut = $urandom_range(1, eff - 1);
            for (int i = 0; i < cut; i++) push_item(sfr_pkg::OP_DATA, pat_word[8*i +: 8]);
            pushed += cut;
          end else begin
            push_item(sfr_pkg::OP_DATA, alpha[$urandom_range(0, 3)]);
            pushed++;
          end
        end
        r = $urandom_range(0, 9);
        if (r < 7) begin
          push_item(sfr_pkg::OP_DATA, sfr_pkg::NEWLINE);
          pushed++;
        end else if (r < 9) begin
          push_item(sfr_pkg::OP_END, 8'($urandom_range(0, 255)));
          pushed++;
        end
      end else begin
        line_len = $urandom_range(1, 6);
        for (int j = 0; j < line_len; j++) begin
          push_item(($urandom_range(0, 5) == 0) ? sfr_pkg::OP_END : sfr_pkg::OP_DATA,
                    8'($urandom_range(0, 255)));
          pushed++;
        end
      end
    end
  endtask

  initial begin
    idle_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a one-byte pattern of zero replaced by zero, i.e. pattern equals
    // replacement. End of stream on a closed line must give nothing.
    push_item(sfr_pkg::OP_DATA, 8'h00);
    push_item(sfr_pkg::OP_DATA, 8'hFF);
    push_item(sfr_pkg::OP_DATA, sfr_pkg::NEWLINE);
    push_item(sfr_pkg::OP_END, 8'hFF);
    push_item(sfr_pkg::OP_END, 8'h00);
    wait_idle();

    // Pattern "ab" with junk in the unused bytes, replacement length above its maximum.
    write_reg(sfr_pkg::CFG_PATTERN, 64'hFFFF_FFFF_FFFF_6261);
    write_reg(sfr_pkg::CFG_PAT_LEN, 64'd2);
    write_reg(sfr_pkg::CFG_REPL, 64'h4847_4645_4443_4241);
    write_reg(sfr_pkg::CFG_REPL_LEN, 64'hF);
    settings_used++;
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_DATA, 8'h62);
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_DATA, 8'h62);
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_DATA, sfr_pkg::NEWLINE);
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_END, 8'h00);
    wait_idle();

    // Pattern shortened while part of it sits in the window; replacement length of zero.
    write_reg(sfr_pkg::CFG_PATTERN, 64'h7A_7978);
    write_reg(sfr_pkg::CFG_PAT_LEN, 64'd3);
    write_reg(sfr_pkg::CFG_REPL, 64'h5F);
    write_reg(sfr_pkg::CFG_REPL_LEN, 64'd0);
    settings_used++;
    push_item(sfr_pkg::OP_DATA, 8'h78);
    push_item(sfr_pkg::OP_DATA, 8'h79);
    wait_idle();
    write_reg(sfr_pkg::CFG_PAT_LEN, 64'd2);
    settings_used++;
    push_item(sfr_pkg::OP_DATA, 8'h78);
    push_item(sfr_pkg::OP_DATA, sfr_pkg::NEWLINE);
    wait_idle();

    // A newline inside the pattern can never match.
    write_reg(sfr_pkg::CFG_PATTERN, 64'h0A61);
    settings_used++;
    push_item(sfr_pkg::OP_DATA, 8'h61);
    push_item(sfr_pkg::OP_DATA, sfr_pkg::NEWLINE);
    push_item(sfr_pkg::OP_END, 8'h61);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config(p);
      idle_on = (p == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      fill_phase(PHASE_ITEMS);
      wait_idle();
    end

    $display("Run covered %0d input beats and %0d output beats over %0d register settings,",
             items_taken, bytes_checked, settings_used);
    $display("with %0d pattern replacements predicted and %0d mismatches.",
             replacements, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
